>>> rtl/core/pbmo_pkg.sv
// Shared constants, state codes and unit request types for the PolyBLEP oscillator.
`default_nettype none

package pbmo_pkg;

   localparam int PHASE_BITS  = 24;
   localparam int PW_BITS     = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int TRI_BITS    = 24;
   localparam int QB          = 30;

   localparam int REQ_W = ((PHASE_BITS + PW_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam int WAVE_W  = 36;
   localparam int BLEP_W  = 32;
   localparam int SUM_W   = WAVE_W + 2;
   localparam int MUL_B_W = 30;
   localparam int PROD_W  = 64;
   localparam int DIV_W   = PHASE_BITS;
   localparam int SHIN_W  = 23;
   localparam int QUO_W   = QB;
   localparam int STEP_W  = 5;
   localparam int P3_W    = PW_BITS + 2;
   localparam int TSUM_W  = TRI_BITS + 3;

   localparam int SAW_SH     = QB - PHASE_BITS + 1;
   localparam int TRI_SH     = 9;
   localparam int TRI_OUT_SH = TRI_SH + 2;
   localparam int INTEG_SH   = QB + TRI_SH - (QB - PHASE_BITS);
   localparam int FADE_SH    = 16;
   localparam int RND_SH     = 31 - SAMPLE_BITS;

   localparam logic [STEP_W-1:0] BLEP_STEPS = STEP_W'(QB);
   localparam logic [STEP_W-1:0] DIV3_STEPS = STEP_W'(SHIN_W);
   localparam logic [DIV_W-1:0]  DIV3_DEN   = DIV_W'(3);

   localparam logic [MUL_B_W-1:0] PULSE_GAIN = MUL_B_W'(759135470);
   localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam logic [PHASE_BITS:0] FULL_PHASE = {1'b1, {PHASE_BITS{1'b0}}};
   localparam logic [PW_BITS:0] FADE_ONE = {1'b1, {PW_BITS{1'b0}}};

   localparam logic signed [WAVE_W-1:0] Q_ONE    = WAVE_W'(1) << QB;
   localparam logic signed [PROD_W-1:0] BIAS_QB  = PROD_W'(1) << (QB - 1);
   localparam logic signed [PROD_W-1:0] BIAS_INT = PROD_W'(1) << (INTEG_SH - 1);
   localparam logic signed [PROD_W-1:0] BIAS_FD  = PROD_W'(1) << (FADE_SH - 1);
   localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(3) << (RND_SH - 1);

   localparam logic signed [TSUM_W-1:0] TRI_MAX = TSUM_W'((1 << (TRI_BITS - 1)) - 1);
   localparam logic signed [TSUM_W-1:0] TRI_MIN = -TSUM_W'(1 << (TRI_BITS - 1));

   localparam logic [SHIN_W-1:0] SMP_POS_LIM = SHIN_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [SHIN_W-1:0] SMP_NEG_LIM = SHIN_W'(1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // edge selectors for the three correction passes
   localparam logic [1:0] EDGE_SAW   = 2'd0;
   localparam logic [1:0] EDGE_PULSE = 2'd1;
   localparam logic [1:0] EDGE_TRI   = 2'd2;

   // thirds of the morph range, from the top bits of 3 * pulse_width
   localparam logic [1:0] MORPH_LOW = 2'd0;
   localparam logic [1:0] MORPH_MID = 2'd1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_BSEL  = 9'b000000010,
      ST_BDIV  = 9'b000000100,
      ST_BSQR  = 9'b000001000,
      ST_GAIN  = 9'b000010000,
      ST_INTEG = 9'b000100000,
      ST_FADE  = 9'b001000000,
      ST_DIV3  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                      start;
      logic signed [WAVE_W-1:0]  a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic                start;
      logic [DIV_W-1:0]    rem;
      logic [SHIN_W-1:0]   shin;
      logic [DIV_W-1:0]    den;
      logic [STEP_W-1:0]   steps;
   } div_req_type;

endpackage

`default_nettype wire

>>> rtl/core/polyblep_morphing_oscillator.sv
// Top level: sequencer, oscillator state and stream ports of the PolyBLEP oscillator.
//
// Usage: each transfer on the req_ channel carries one phase step and one
// pulse width and yields exactly one transfer on the rsp_ channel: the next
// signed audio sample. The block holds the phase accumulator and the leaky
// integrator memory that turns the corrected two-level wave into a triangle.
// Timing: one item is in work at a time. The shortest run to rsp_tvalid is in
// the upper third of the pulse-width range with no wave edge within one step of
// the phase; the two morph fades of the lower and middle thirds and each edge
// correction lengthen it. The next item can be accepted in the cycle after the
// result is loaded. The serial operations run 30 steps for an edge division,
// an edge square, the pulse gain, the integrator and each fade, and 23 steps
// for the output divide by three.
// Reset: phase and integrator memory clear to zero, the result slot empties
// and the block is ready for an item in the next cycle.
// Stall: a finished sample waits in the output register while the next item
// is already accepted and worked on; the sequencer holds its own result
// until the output register is free.
`default_nettype none

module polyblep_morphing_oscillator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pbmo_pkg::REQ_W-1:0]      req_tdata,   // [23:0] phase_step, [39:24] pulse_width
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pbmo_pkg::RSP_W-1:0]      rsp_tdata    // [15:0] sample
);

   localparam int PB = pbmo_pkg::PHASE_BITS;
   localparam int WW = pbmo_pkg::WAVE_W;

   pbmo_pkg::state_type                    state_ff, state_in;
   logic                                   busy_ff, busy_in;
   logic [1:0]                             k_ff, k_in;
   logic                                   rise_ff, rise_in;
   logic                                   fstep_ff, fstep_in;
   logic [PB-1:0]                          num_ff, num_in;
   logic [pbmo_pkg::QUO_W-1:0]             u_ff, u_in;
   logic signed [pbmo_pkg::BLEP_W-1:0]     b_ff [3];
   logic signed [pbmo_pkg::BLEP_W-1:0]     b_in [3];
   logic [PB-1:0]                          ph_ff, ph_in;
   logic signed [pbmo_pkg::TRI_BITS-1:0]   mem_ff, mem_in;
   logic [PB-1:0]                          inc_ff, inc_in;
   logic [pbmo_pkg::PW_BITS-1:0]           pw16_ff, pw16_in;
   logic signed [WW-1:0]                   saw_ff, saw_in;
   logic signed [WW-1:0]                   sq_ff, sq_in;
   logic signed [WW-1:0]                   tri_ff, tri_in;
   logic [pbmo_pkg::SAMPLE_BITS-1:0]       smp_ff, smp_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [pbmo_pkg::SAMPLE_BITS-1:0]       rsp_data_ff, rsp_data_in;

   pbmo_pkg::mul_req_type                  mul_req;
   pbmo_pkg::div_req_type                  div_req;
   logic                                   mul_done, div_done;
   logic signed [pbmo_pkg::PROD_W-1:0]     mul_prod;
   logic [pbmo_pkg::QUO_W-1:0]             div_quo;

   logic [PB-1:0]                          pw_full, t_sel;
   logic                                   t_lt, t_hi;
   logic signed [WW-1:0]                   b0e, b1e, b2e, u2, r36, blep_val;
   logic signed [WW-1:0]                   sq0, saw_val, triw, mem_sh, integ_d, t_sh;
   logic signed [pbmo_pkg::PROD_W-1:0]     rnd30, rnd33, rnd16;
   logic signed [pbmo_pkg::TSUM_W-1:0]     tsum;
   logic signed [pbmo_pkg::TRI_BITS-1:0]   tsat;
   logic [pbmo_pkg::P3_W-1:0]              p3;
   logic [pbmo_pkg::PW_BITS-1:0]           fade;
   logic [pbmo_pkg::PW_BITS:0]             two_f, f2, inv_fade;
   logic signed [pbmo_pkg::SUM_W-1:0]      sum;
   logic [pbmo_pkg::SUM_W-1:0]             mag, nq;
   logic [pbmo_pkg::SHIN_W-1:0]            q;
   logic                                   accept;

   pbmo_sermul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pbmo_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   // datapath terms, from registers that hold still during an operation and from the unit results
   always_comb begin
      pw_full = {pw16_ff, {(PB - pbmo_pkg::PW_BITS){1'b0}}};
      case (k_ff)
         pbmo_pkg::EDGE_SAW:   t_sel = ph_ff;
         pbmo_pkg::EDGE_PULSE: t_sel = ph_ff - pw_full;
         pbmo_pkg::EDGE_TRI:   t_sel = ph_ff + pbmo_pkg::HALF_PHASE;
         default:              t_sel = ph_ff;
      endcase
      t_lt = t_sel < inc_ff;
      t_hi = ({1'b0, t_sel} + {1'b0, inc_ff}) > pbmo_pkg::FULL_PHASE;

      b0e = WW'(b_ff[0]);
      b1e = WW'(b_ff[1]);
      b2e = WW'(b_ff[2]);

      rnd30 = (mul_prod + pbmo_pkg::BIAS_QB) >>> pbmo_pkg::QB;
      rnd33 = (mul_prod + pbmo_pkg::BIAS_INT) >>> pbmo_pkg::INTEG_SH;
      rnd16 = (mul_prod + pbmo_pkg::BIAS_FD) >>> pbmo_pkg::FADE_SH;

      // correction polynomial from the ratio u and its rounded square
      u2       = {{(WW - pbmo_pkg::QUO_W - 1){1'b0}}, u_ff, 1'b0};
      r36      = WW'(rnd30);
      blep_val = rise_ff ? (u2 - r36 - pbmo_pkg::Q_ONE) : (r36 - u2 + pbmo_pkg::Q_ONE);

      sq0     = ((ph_ff < pw_full) ? pbmo_pkg::Q_ONE : -pbmo_pkg::Q_ONE) + b0e - b1e;
      saw_val = pbmo_pkg::Q_ONE + b0e
              - {{(WW - PB - pbmo_pkg::SAW_SH){1'b0}}, ph_ff, {pbmo_pkg::SAW_SH{1'b0}}};
      triw    = (ph_ff[PB-1] ? -pbmo_pkg::Q_ONE : pbmo_pkg::Q_ONE) + b0e - b2e;
      mem_sh  = {{(WW - pbmo_pkg::TRI_BITS - pbmo_pkg::TRI_SH){mem_ff[pbmo_pkg::TRI_BITS-1]}},
                 mem_ff, {pbmo_pkg::TRI_SH{1'b0}}};
      // leak form: inc*(tri - mem) + mem, so one product serves the integrator
      integ_d = triw - mem_sh;

      tsum = pbmo_pkg::TSUM_W'(rnd33) + pbmo_pkg::TSUM_W'(mem_ff);
      if (tsum > pbmo_pkg::TRI_MAX)      tsat = pbmo_pkg::TRI_BITS'(pbmo_pkg::TRI_MAX);
      else if (tsum < pbmo_pkg::TRI_MIN) tsat = pbmo_pkg::TRI_BITS'(pbmo_pkg::TRI_MIN);
      else                               tsat = pbmo_pkg::TRI_BITS'(tsum);
      t_sh = {{(WW - pbmo_pkg::TRI_BITS - pbmo_pkg::TRI_OUT_SH){tsat[pbmo_pkg::TRI_BITS-1]}},
              tsat, {pbmo_pkg::TRI_OUT_SH{1'b0}}};

      p3       = {2'b00, pw16_ff} + {1'b0, pw16_ff, 1'b0};
      fade     = p3[pbmo_pkg::PW_BITS-1:0];
      inv_fade = pbmo_pkg::FADE_ONE - {1'b0, fade};
      two_f    = {fade, 1'b0};
      f2       = (two_f > pbmo_pkg::FADE_ONE) ? '0 : (pbmo_pkg::FADE_ONE - two_f);

      // mean of the three waves: round half away from zero, scale by 3 * 2^15
      sum = pbmo_pkg::SUM_W'(saw_ff) + pbmo_pkg::SUM_W'(tri_ff) + pbmo_pkg::SUM_W'(sq_ff);
      mag = sum[pbmo_pkg::SUM_W-1] ? pbmo_pkg::SUM_W'(-sum) : pbmo_pkg::SUM_W'(sum);
      nq  = (mag + pbmo_pkg::RND_HALF) >> pbmo_pkg::RND_SH;
      q   = div_quo[pbmo_pkg::SHIN_W-1:0];
   end

   assign accept = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      k_in         = k_ff;
      rise_in      = rise_ff;
      fstep_in     = fstep_ff;
      num_in       = num_ff;
      u_in         = u_ff;
      b_in         = b_ff;
      ph_in        = ph_ff;
      mem_in       = mem_ff;
      inc_in       = inc_ff;
      pw16_in      = pw16_ff;
      saw_in       = saw_ff;
      sq_in        = sq_ff;
      tri_in       = tri_ff;
      smp_in       = smp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      mul_req       = '0;
      div_req       = '0;
      div_req.steps = pbmo_pkg::BLEP_STEPS;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pbmo_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               inc_in   = req_tdata[PB-1:0];
               pw16_in  = req_tdata[PB +: pbmo_pkg::PW_BITS];
               k_in     = pbmo_pkg::EDGE_SAW;
               state_in = pbmo_pkg::ST_BSEL;
            end
         end

         pbmo_pkg::ST_BSEL: begin
            if (inc_ff != '0 && t_lt) begin
               rise_in  = 1'b1;
               num_in   = t_sel;
               state_in = pbmo_pkg::ST_BDIV;
            end else if (inc_ff != '0 && t_hi) begin
               rise_in  = 1'b0;
               num_in   = PB'(0) - t_sel;
               state_in = pbmo_pkg::ST_BDIV;
            end else begin
               b_in[k_ff] = '0;
               if (k_ff == pbmo_pkg::EDGE_TRI) begin
                  state_in = pbmo_pkg::ST_GAIN;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end

         pbmo_pkg::ST_BDIV: begin
            div_req.rem   = num_ff;
            div_req.den   = inc_ff;
            div_req.steps = pbmo_pkg::BLEP_STEPS;
            if (!busy_ff) begin
               div_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (div_done) begin
               busy_in  = 1'b0;
               u_in     = div_quo;
               state_in = pbmo_pkg::ST_BSQR;
            end
         end

         pbmo_pkg::ST_BSQR: begin
            mul_req.a = {{(WW - pbmo_pkg::QUO_W){1'b0}}, u_ff};
            mul_req.b = u_ff;
            if (!busy_ff) begin
               mul_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (mul_done) begin
               busy_in    = 1'b0;
               b_in[k_ff] = pbmo_pkg::BLEP_W'(blep_val);
               if (k_ff == pbmo_pkg::EDGE_TRI) begin
                  state_in = pbmo_pkg::ST_GAIN;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = pbmo_pkg::ST_BSEL;
               end
            end
         end

         pbmo_pkg::ST_GAIN: begin
            mul_req.a = sq0;
            mul_req.b = pbmo_pkg::PULSE_GAIN;
            if (!busy_ff) begin
               mul_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               sq_in    = -WW'(rnd30);
               saw_in   = saw_val;
               state_in = pbmo_pkg::ST_INTEG;
            end
         end

         pbmo_pkg::ST_INTEG: begin
            mul_req.a = integ_d;
            mul_req.b = pbmo_pkg::MUL_B_W'(inc_ff);
            if (!busy_ff) begin
               mul_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               mem_in   = tsat;
               tri_in   = -t_sh;
               // advance and wrap the phase
               ph_in    = ph_ff + inc_ff;
               fstep_in = 1'b0;
               state_in = pbmo_pkg::ST_FADE;
            end
         end

         pbmo_pkg::ST_FADE: begin
            case (p3[pbmo_pkg::P3_W-1 -: 2])
               pbmo_pkg::MORPH_LOW: begin
                  mul_req.a = fstep_ff ? sq_ff : tri_ff;
                  mul_req.b = pbmo_pkg::MUL_B_W'(fade);
               end
               pbmo_pkg::MORPH_MID: begin
                  mul_req.a = fstep_ff ? tri_ff : saw_ff;
                  mul_req.b = fstep_ff ? pbmo_pkg::MUL_B_W'(f2) : pbmo_pkg::MUL_B_W'(inv_fade);
               end
               default: begin
                  mul_req.a = tri_ff;
                  mul_req.b = '0;
               end
            endcase
            if (p3[pbmo_pkg::P3_W-1]) begin
               // upper third: pulse alone
               tri_in   = '0;
               saw_in   = '0;
               state_in = pbmo_pkg::ST_DIV3;
            end else if (!busy_ff) begin
               mul_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (mul_done) begin
               busy_in = 1'b0;
               if (p3[pbmo_pkg::P3_W-1 -: 2] == pbmo_pkg::MORPH_LOW) begin
                  if (fstep_ff) sq_in  = WW'(rnd16);
                  else          tri_in = WW'(rnd16);
               end else begin
                  if (fstep_ff) tri_in = WW'(rnd16);
                  else          saw_in = WW'(rnd16);
               end
               fstep_in = 1'b1;
               if (fstep_ff) begin
                  state_in = pbmo_pkg::ST_DIV3;
               end
            end
         end

         pbmo_pkg::ST_DIV3: begin
            div_req.rem   = '0;
            div_req.shin  = nq[pbmo_pkg::SHIN_W-1:0];
            div_req.den   = pbmo_pkg::DIV3_DEN;
            div_req.steps = pbmo_pkg::DIV3_STEPS;
            if (!busy_ff) begin
               div_req.start = 1'b1;
               busy_in       = 1'b1;
            end else if (div_done) begin
               busy_in = 1'b0;
               // saturate to the sample range
               if (sum[pbmo_pkg::SUM_W-1]) begin
                  smp_in = (q > pbmo_pkg::SMP_NEG_LIM) ? pbmo_pkg::SMP_MIN
                         : pbmo_pkg::SAMPLE_BITS'(pbmo_pkg::SHIN_W'(0) - q);
               end else begin
                  smp_in = (q > pbmo_pkg::SMP_POS_LIM) ? pbmo_pkg::SMP_MAX
                         : pbmo_pkg::SAMPLE_BITS'(q);
               end
               state_in = pbmo_pkg::ST_OUT;
            end
         end

         pbmo_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = smp_ff;
               rsp_valid_in = 1'b1;
               state_in     = pbmo_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pbmo_pkg::ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbmo_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         ph_ff        <= '0;
         mem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         ph_ff        <= ph_in;
         mem_ff       <= mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      rise_ff     <= rise_in;
      fstep_ff    <= fstep_in;
      num_ff      <= num_in;
      u_ff        <= u_in;
      b_ff        <= b_in;
      inc_ff      <= inc_in;
      pw16_ff     <= pw16_in;
      saw_ff      <= saw_in;
      sq_ff       <= sq_in;
      tri_ff      <= tri_in;
      smp_ff      <= smp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pbmo_pkg::RSP_W'(rsp_data_ff);

`ifndef SYNTH
   a_mul_done_owned: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == pbmo_pkg::ST_BSQR || state_ff == pbmo_pkg::ST_GAIN ||
                    state_ff == pbmo_pkg::ST_INTEG || state_ff == pbmo_pkg::ST_FADE))
      else $error("multiplier finished outside a multiply step");

   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pbmo_pkg::ST_BDIV || state_ff == pbmo_pkg::ST_DIV3))
      else $error("divider finished outside a divide step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == pbmo_pkg::ST_BSEL)
      else $error("accepted item did not start edge selection");

   a_zero_inc_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbmo_pkg::ST_INTEG && mul_done && inc_ff == '0)
         |=> mem_ff == $past(mem_ff))
      else $error("integrator moved with zero increment");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbmo_pkg::ST_OUT && rsp_valid_ff && !rsp_tready)
         |=> (state_ff == pbmo_pkg::ST_OUT && rsp_tvalid))
      else $error("result overwrote a pending sample");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pbmo_sermul.sv
// Bit-serial shift-add multiplier, signed by unsigned, one multiplier bit per cycle.
`default_nettype none

module pbmo_sermul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pbmo_pkg::mul_req_type                 req,
   output logic                                  done,
   output logic signed [pbmo_pkg::PROD_W-1:0]    prod
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [pbmo_pkg::STEP_W-1:0]           cnt_ff, cnt_in;
   logic signed [pbmo_pkg::WAVE_W-1:0]    a_ff, a_in;
   logic [pbmo_pkg::MUL_B_W-1:0]          b_ff, b_in;
   logic signed [pbmo_pkg::PROD_W-1:0]    p_ff, p_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = pbmo_pkg::STEP_W'(pbmo_pkg::MUL_B_W - 1);
         a_in    = req.a;
         b_in    = req.b;
         p_in    = '0;
      end else if (busy_ff) begin
         // MSB first: double the partial sum, add the multiplicand on a one bit
         p_in = (p_ff <<< 1)
              + (b_ff[pbmo_pkg::MUL_B_W-1] ? pbmo_pkg::PROD_W'(a_ff) : '0);
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign done = done_ff;
   assign prod = p_ff;

endmodule

`default_nettype wire

>>> rtl/core/pbmo_serdiv.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module pbmo_serdiv (
   input  logic                            clock,
   input  logic                            reset,
   input  pbmo_pkg::div_req_type           req,
   output logic                            done,
   output logic [pbmo_pkg::QUO_W-1:0]      quo
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pbmo_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [pbmo_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [pbmo_pkg::SHIN_W-1:0]     sh_ff, sh_in;
   logic [pbmo_pkg::DIV_W-1:0]      den_ff, den_in;
   logic [pbmo_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [pbmo_pkg::DIV_W:0]        trial;
   logic                            fits;

   always_comb begin
      trial   = {rem_ff, sh_ff[pbmo_pkg::SHIN_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps - 1'b1;
         rem_in  = req.rem;
         sh_in   = req.shin;
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so one subtract settles each bit
         rem_in = fits ? pbmo_pkg::DIV_W'(trial - {1'b0, den_ff})
                       : trial[pbmo_pkg::DIV_W-1:0];
         quo_in = {quo_ff[pbmo_pkg::QUO_W-2:0], fits};
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire
